// File: rtl/core/lps_pkg.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer package
// Shared types, constants and table helpers for the LED pattern sequencer.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int NUM_PATTERNS = 5;
  localparam int MODE_W       = 3;
  localparam int ENTRY_W      = 43;
  localparam int CFG_ADDR_W   = 3;

  localparam logic [7:0] COUNT_FOREVER = 8'hff;
  localparam logic [7:0] DRIVE_STEADY  = 8'd250;
  localparam logic [7:0] RAMP_TOP      = 8'd252;
  localparam logic [7:0] RAMP_FLOOR    = 8'd3;
  localparam logic [7:0] RAMP_MIN      = 8'd2;
  localparam logic [7:0] RAMP_STEP     = 8'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_TICK_MS   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDLE_HOLD = 3'd6;

  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_ENTER = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    CHG_NONE     = 2'd0,
    CHG_CHARGING = 2'd1,
    CHG_FULL     = 2'd2,
    CHG_OTHER    = 2'd3
  } charge_t;

  typedef struct packed {
    logic [MODE_W-1:0] chain_mode;
    logic [7:0]        count;
    logic [15:0]       on_ms;
    logic [15:0]       off_ms;
  } entry_t;

  typedef entry_t [NUM_PATTERNS-1:0] entry_table_t;

  typedef struct packed {
    entry_table_t entries;
    logic [7:0]   tick_ms;
    logic [15:0]  idle_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode_index;
    logic [7:0]        repeat_left;
    logic              phase_on;
    logic [15:0]       time_left_ms;
    logic [7:0]        ramp_value;
    logic              ramp_rising;
    logic              hold_flag;
    logic              idle_armed;
    logic [15:0]       idle_elapsed_ms;
  } state_t;

  typedef struct packed {
    logic              led_on;
    logic [7:0]        pwm_duty;
    logic              awake_hold;
    logic [MODE_W-1:0] active_mode;
    logic              stepped;
  } result_t;

  function automatic logic mode_valid(input logic [MODE_W-1:0] m);
    return ({29'd0, m} < NUM_PATTERNS);
  endfunction

  function automatic entry_t entry_of(input entry_table_t tbl, input logic [MODE_W-1:0] m);
    entry_t e;
    e = '0;
    if (mode_valid(m)) begin
      e = tbl[m];
    end
    return e;
  endfunction

  function automatic entry_t entry_reset(input int idx);
    entry_t e;
    e = '0;
    case (idx)
      1: e = '{chain_mode: 3'd3, count: 8'd1, on_ms: 16'd2000, off_ms: 16'd0};
      2: e = '{chain_mode: 3'd0, count: 8'd1, on_ms: 16'd100, off_ms: 16'd0};
      3: e = '{chain_mode: 3'd3, count: COUNT_FOREVER, on_ms: 16'd100, off_ms: 16'd900};
      4: e = '{chain_mode: 3'd4, count: COUNT_FOREVER, on_ms: 16'd1000, off_ms: 16'd0};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

// File: rtl/core/lps_in_if.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer request channel
// Valid/ready channel that carries one tick or enter-mode request.
// ----------------------------------------------------------------------------
interface lps_in_if
  import lps_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [MODE_W-1:0] new_mode;
  logic [1:0]        charge_state;

  modport source(output valid, output req_type, output new_mode, output charge_state,
                 input ready);
  modport sink(input valid, input req_type, input new_mode, input charge_state,
               output ready);
endinterface

// File: rtl/core/lps_out_if.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer result channel
// Valid/ready channel that carries the LED drive result of one request.
// ----------------------------------------------------------------------------
interface lps_out_if
  import lps_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              led_on;
  logic [7:0]        pwm_duty;
  logic              awake_hold;
  logic [MODE_W-1:0] active_mode;
  logic              stepped;

  modport source(output valid, output led_on, output pwm_duty, output awake_hold,
                 output active_mode, output stepped, input ready);
  modport sink(input valid, input led_on, input pwm_duty, input awake_hold,
               input active_mode, input stepped, output ready);
endinterface

// File: rtl/core/led_pattern_sequencer_core.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer core
// Table-driven LED blink engine with a breathing PWM drive and awake hold.
// ----------------------------------------------------------------------------
// The result of a request is registered and valid in the cycle after it is accepted.
// Throughput: one request per cycle while results drain; state updates in one pass.
// The result register frees itself in the cycle its result is taken.
// Reset (synchronous, rst_n low) clears the sequencer state and the result
// valid flag and restores the default pattern table and timing registers.
module led_pattern_sequencer_core
  import lps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  lps_in_if.sink                in_req,
  lps_out_if.source             out_res,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ENTRY_W-1:0]    cfg_wdata
);

  cfg_t    cfg_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t res_nxt;
  result_t out_r;
  logic    out_valid_r;
  logic    in_fire;

  assign in_req.ready = !out_valid_r || out_res.ready;
  assign in_fire      = in_req.valid && in_req.ready;

  lps_step u_step (
    .cfg          (cfg_r),
    .st           (state_r),
    .req_type     (in_req.req_type),
    .new_mode     (in_req.new_mode),
    .charge_state (in_req.charge_state),
    .st_nxt       (state_nxt),
    .res          (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PATTERNS; i++) begin
        cfg_r.entries[i] <= entry_reset(i);
      end
      cfg_r.tick_ms      <= 8'd10;
      cfg_r.idle_hold_ms <= 16'd1000;
    end else if (cfg_we) begin
      for (int i = 0; i < NUM_PATTERNS; i++) begin
        if ({29'd0, cfg_addr} == i) begin
          cfg_r.entries[i] <= cfg_wdata;
        end
      end
      if (cfg_addr == CFG_TICK_MS) begin
        cfg_r.tick_ms <= cfg_wdata[7:0];
      end
      if (cfg_addr == CFG_IDLE_HOLD) begin
        cfg_r.idle_hold_ms <= cfg_wdata[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= res_nxt;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.led_on      = out_r.led_on;
  assign out_res.pwm_duty    = out_r.pwm_duty;
  assign out_res.awake_hold  = out_r.awake_hold;
  assign out_res.active_mode = out_r.active_mode;
  assign out_res.stepped     = out_r.stepped;

  a_mode_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mode_valid(state_r.mode_index))
    else $error("sequencer mode index out of range");

  a_enter_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_req.req_type == REQ_ENTER) |=> (out_res.valid && !out_res.stepped))
    else $error("enter-mode request reported a pattern step");

  a_off_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.led_on) |-> (out_res.pwm_duty == 8'd0))
    else $error("PWM driven while the LED phase is off");

  a_ramp_even: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.ramp_value[0] == 1'b0)
    else $error("breathing ramp left its even grid");

endmodule

// File: rtl/core/lps_step.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer step logic
// Computes the next sequencer state and the result for one request.
// ----------------------------------------------------------------------------
module lps_step
  import lps_pkg::*;
(
  input  cfg_t              cfg,
  input  state_t            st,
  input  logic              req_type,
  input  logic [MODE_W-1:0] new_mode,
  input  logic [1:0]        charge_state,
  output state_t            st_nxt,
  output result_t           res
);

  always_comb begin
    state_t      s;
    entry_t      cur;
    logic [7:0]  duty;
    logic        stepped;
    logic [16:0] idle_sum;
    logic [7:0]  ramp_tmp;

    s        = st;
    duty     = '0;
    stepped  = 1'b0;
    idle_sum = '0;
    ramp_tmp = '0;
    cur      = '0;

    if (req_type == REQ_ENTER) begin
      if (mode_valid(new_mode)) begin
        cur            = entry_of(cfg.entries, new_mode);
        s.repeat_left  = cur.count;
        s.mode_index   = new_mode;
        s.phase_on     = 1'b0;
        s.time_left_ms = '0;
      end
      duty = s.phase_on ? s.ramp_value : 8'd0;
    end else begin
      if (s.mode_index != '0) begin
        if (s.time_left_ms > {8'd0, cfg.tick_ms}) begin
          s.time_left_ms = s.time_left_ms - {8'd0, cfg.tick_ms};
        end else begin
          stepped = 1'b1;
          if (s.phase_on && s.repeat_left != 8'd0 && s.repeat_left != COUNT_FOREVER) begin
            s.repeat_left = s.repeat_left - 8'd1;
          end
          if (s.repeat_left == 8'd0) begin
            cur = entry_of(cfg.entries, s.mode_index);
            s.mode_index  = mode_valid(cur.chain_mode) ? cur.chain_mode : '0;
            cur = entry_of(cfg.entries, s.mode_index);
            s.repeat_left = cur.count;
          end
          cur = entry_of(cfg.entries, s.mode_index);
          if (s.repeat_left != 8'd0 && cur.off_ms == 16'd0) begin
            s.phase_on = 1'b1;
          end else begin
            s.phase_on = ~s.phase_on;
          end
          s.time_left_ms = s.phase_on ? cur.on_ms : cur.off_ms;
        end
      end

      if (s.mode_index != '0) begin
        s.hold_flag       = 1'b1;
        s.idle_armed      = 1'b1;
        s.idle_elapsed_ms = '0;
      end else if (s.idle_armed) begin
        idle_sum = {1'b0, s.idle_elapsed_ms} + {9'd0, cfg.tick_ms};
        if (idle_sum > {1'b0, cfg.idle_hold_ms}) begin
          s.idle_armed = 1'b0;
          s.hold_flag  = 1'b0;
        end else begin
          s.idle_elapsed_ms = idle_sum[15:0];
        end
      end

      if (s.phase_on) begin
        if (charge_state == CHG_NONE || charge_state == CHG_FULL) begin
          s.ramp_value = DRIVE_STEADY;
        end else if (s.ramp_rising) begin
          ramp_tmp = s.ramp_value + RAMP_STEP;
          if (ramp_tmp > RAMP_TOP) begin
            s.ramp_value  = RAMP_TOP;
            s.ramp_rising = 1'b0;
          end else begin
            s.ramp_value = ramp_tmp;
          end
        end else begin
          ramp_tmp = s.ramp_value - RAMP_STEP;
          if (ramp_tmp < RAMP_FLOOR) begin
            s.ramp_value  = RAMP_MIN;
            s.ramp_rising = 1'b1;
          end else begin
            s.ramp_value = ramp_tmp;
          end
        end
        duty = s.ramp_value;
      end
    end

    st_nxt          = s;
    res.led_on      = s.phase_on;
    res.pwm_duty    = duty;
    res.awake_hold  = s.hold_flag;
    res.active_mode = s.mode_index;
    res.stepped     = stepped;
  end

endmodule
